// File: src/bb3_pkg.sv
package bb3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W     = 16;
    localparam int IN_ROW_W  = ROW_W + 1;
    localparam int CH_W      = 8;
    localparam int CFG_WID_W = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam int SUM_W  = 12;
    localparam int NUM_W  = SUM_W + 1;
    localparam int CNT_W  = 4;
    localparam int DEN_W  = CNT_W + 1;
    localparam int RCP_SH = 17;
    localparam int RCP_W  = RCP_SH;
    localparam int PRD_W  = NUM_W + RCP_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_MUL,
        ST_FIX
    } t_state;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    function automatic logic [WID_W-1:0] eff_width(input logic [CFG_WID_W-1:0] v);
        int unsigned t;
        t = v;
        if (t == 0) t = 1;
        if (t > MAX_WIDTH) t = MAX_WIDTH;
        return WID_W'(t);
    endfunction

    function automatic logic [ROW_W-1:0] eff_height(input logic [ROW_W-1:0] v);
        return (v == '0) ? ROW_W'(1) : v;
    endfunction

    // floor(2^RCP_SH / (2*cnt))
    function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RCP_W-1:0] m;
        unique case (cnt)
            4'd1:    m = RCP_W'(65536);
            4'd2:    m = RCP_W'(32768);
            4'd3:    m = RCP_W'(21845);
            4'd4:    m = RCP_W'(16384);
            4'd5:    m = RCP_W'(13107);
            4'd6:    m = RCP_W'(10922);
            4'd7:    m = RCP_W'(9362);
            4'd8:    m = RCP_W'(8192);
            4'd9:    m = RCP_W'(7281);
            default: m = RCP_W'(65536);
        endcase
        return m;
    endfunction

endpackage

// File: src/bb3_pix_if.sv
interface bb3_pix_if import bb3_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            op;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;

    modport source (output valid, output op, output in_red, output in_green,
                    output in_blue, input ready);
    modport sink   (input valid, input op, input in_red, input in_green,
                    input in_blue, output ready);
endinterface

// File: src/bb3_out_if.sv
interface bb3_out_if import bb3_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            last_of_frame;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output last_of_frame, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input last_of_frame, output ready);
endinterface

// File: src/bb3_cfg_if.sv
interface bb3_cfg_if import bb3_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/box_blur_3x3_stream.sv
// Channel  Dir  Word
// i_pix    in   op, in_red, in_green, in_blue
// o_blur   out  out_red, out_green, out_blue, last_of_frame
// i_cfg    in   index (0 frame_width, 1 frame_height), data
//
// A word with a result goes from acceptance to the output register through
// line store read, window shift and write back, tap sum, reciprocal multiply,
// remainder fix. A word with no result ends after the write back, an ignored
// drain at acceptance. One word is in flight at a time. The output register
// lets the next word enter while a result waits; a stalled output holds the fix step.
// Reset is synchronous; line stores are not cleared. Config is always ready.
module box_blur_3x3_stream import bb3_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bb3_pix_if.sink   i_pix,
    bb3_out_if.source o_blur,
    bb3_cfg_if.sink   i_cfg
);

    t_rgb line_prev  [MAX_WIDTH];
    t_rgb line_prev2 [MAX_WIDTH];

    t_state r_state, n_state;

    logic [WID_W-1:0]    r_width;
    logic [ROW_W-1:0]    r_height;
    logic [COL_W-1:0]    r_in_col, r_out_col;
    logic [IN_ROW_W-1:0] r_in_row;
    logic [ROW_W-1:0]    r_out_row;
    t_rgb                r_win [9];

    t_rgb r_pix, r_t1, r_t2;

    logic [NUM_W-1:0] r_x [3];
    logic [DEN_W-1:0] r_d;
    logic [RCP_W-1:0] r_m;
    logic [PRD_W-1:0] r_prod [3];
    logic             r_last;

    logic            r_out_valid;
    logic [CH_W-1:0] r_out_ch [3];
    logic            r_out_last;

    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;
    logic             in_take, cfg_take, in_frame, ignore, start, emit, load_ok;
    logic             in_ready, mem_rd, mem_wr, do_sum, do_mul, do_load;
    logic             last;
    logic [1:0]       rows, cols;
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum [3];
    logic [CH_W-1:0]  q   [3];

    assign w_m1 = COL_W'(r_width - WID_W'(1));
    assign h_m1 = r_height - ROW_W'(1);

    assign in_take  = i_pix.valid && i_pix.ready;
    assign cfg_take = i_cfg.valid && i_cfg.ready;
    assign in_frame = r_in_row < {1'b0, r_height};
    assign ignore   = i_pix.op && in_frame;
    assign start    = in_take && !ignore;
    assign emit     = !((r_in_row == '0) || ((r_in_row == IN_ROW_W'(1)) && (r_in_col == '0)));
    assign load_ok  = !r_out_valid || o_blur.ready;
    assign last     = (r_out_row == h_m1) && (r_out_col == w_m1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (start) n_state = ST_READ;
            ST_READ: n_state = emit ? ST_SUM : ST_IDLE;
            ST_SUM:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_FIX;
            ST_FIX:  if (load_ok) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        mem_wr   = 1'b0;
        do_sum   = 1'b0;
        do_mul   = 1'b0;
        do_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: in_ready = 1'b1;
            ST_READ: mem_wr   = 1'b1;
            ST_SUM:  do_sum   = 1'b1;
            ST_MUL:  do_mul   = 1'b1;
            ST_FIX:  do_load  = load_ok;
            default: in_ready = 1'b0;
        endcase
    end

    assign mem_rd = start;

    assign i_pix.ready          = in_ready;
    assign i_cfg.ready          = 1'b1;
    assign o_blur.valid         = r_out_valid;
    assign o_blur.out_red       = r_out_ch[0];
    assign o_blur.out_green     = r_out_ch[1];
    assign o_blur.out_blue      = r_out_ch[2];
    assign o_blur.last_of_frame = r_out_last;

    always_ff @(posedge i_clk) begin
        if (mem_rd) begin
            r_t1 <= line_prev[r_in_col];
            r_t2 <= line_prev2[r_in_col];
        end
        if (mem_wr) begin
            line_prev[r_in_col]  <= r_pix;
            line_prev2[r_in_col] <= r_t1;
        end
    end

    // mask out-of-frame taps, count the valid ones and sum each channel
    always_comb begin
        logic rv [3];
        logic cv [3];
        logic [CH_W-1:0] ch;
        rv[0] = r_out_row != h_m1;
        rv[1] = 1'b1;
        rv[2] = r_out_row != '0;
        cv[0] = r_out_col != w_m1;
        cv[1] = 1'b1;
        cv[2] = r_out_col != '0;
        rows  = 2'd1 + 2'(rv[0]) + 2'(rv[2]);
        cols  = 2'd1 + 2'(cv[0]) + 2'(cv[2]);
        cnt   = CNT_W'(rows) * CNT_W'(cols);
        for (int c = 0; c < 3; c++) sum[c] = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (rv[i] && cv[j]) begin
                    for (int c = 0; c < 3; c++) begin
                        unique case (c)
                            0:       ch = r_win[i*3+j].red;
                            1:       ch = r_win[i*3+j].green;
                            default: ch = r_win[i*3+j].blue;
                        endcase
                        sum[c] = sum[c] + SUM_W'(ch);
                    end
                end
            end
        end
    end

    always_comb begin
        logic [CH_W-1:0]  q0;
        logic [NUM_W-1:0] rem;
        for (int c = 0; c < 3; c++) begin
            q0   = r_prod[c][RCP_SH +: CH_W];
            rem  = r_x[c] - (NUM_W'(q0) * NUM_W'(r_d));
            q[c] = (rem >= NUM_W'(r_d)) ? q0 + CH_W'(1) : q0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_pix <= in_frame ? t_rgb'{i_pix.in_red, i_pix.in_green, i_pix.in_blue} : '0;
        end
        if (do_sum) begin
            for (int c = 0; c < 3; c++) r_x[c] <= {sum[c], 1'b0} + NUM_W'(cnt);
            r_d    <= {cnt, 1'b0};
            r_m    <= recip(cnt);
            r_last <= last;
        end
        if (do_mul) begin
            for (int c = 0; c < 3; c++) r_prod[c] <= PRD_W'(r_x[c]) * PRD_W'(r_m);
        end
        if (do_load) begin
            for (int c = 0; c < 3; c++) r_out_ch[c] <= q[c];
            r_out_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_width     <= eff_width(CFG_WID_W'(1024));
            r_height    <= ROW_W'(1024);
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
        end else begin
            r_state <= n_state;

            if (mem_wr) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i*3+2] <= r_win[i*3+1];
                    r_win[i*3+1] <= r_win[i*3];
                end
                r_win[0] <= r_pix;
                r_win[3] <= r_t1;
                r_win[6] <= r_t2;
                if (r_in_col == w_m1) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + IN_ROW_W'(1);
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
            end

            if (do_sum) begin
                if (last) begin
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end else if (r_out_col == w_m1) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + ROW_W'(1);
                end else begin
                    r_out_col <= r_out_col + COL_W'(1);
                end
            end

            if (do_load) begin
                r_out_valid <= 1'b1;
            end else if (o_blur.ready) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_take) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_FRAME_WIDTH:  r_width  <= eff_width(i_cfg.data[CFG_WID_W-1:0]);
                    CFG_FRAME_HEIGHT: r_height <= eff_height(i_cfg.data[ROW_W-1:0]);
                    default:          r_width  <= r_width;
                endcase
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                for (int k = 0; k < 9; k++) r_win[k] <= '0;
            end
        end
    end

endmodule
